// File: hdl/rthsv_pkg.sv
`default_nettype none

package rthsv_pkg;

   localparam int PIX_W = 8;
   // dividend holds 256 * 1530 plus rounding, shifted divisor holds 6 * 255 << 7
   localparam int NUM_W = 19;
   localparam int DSH_W = 18;
   localparam int DIV_STAGES = PIX_W;

   typedef enum logic [1:0] {
      SECT_RED_POS,
      SECT_RED_NEG,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [DSH_W-1:0] dsh;
      logic [PIX_W-1:0] quo;
   } lane_type;

   typedef struct packed {
      lane_type         sat;
      lane_type         hue;
      logic             neg;
      logic [PIX_W-1:0] bright;
   } div_type;

endpackage

`default_nettype wire

// File: hdl/rthsv_front.sv
`default_nettype none

module rthsv_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [rthsv_pkg::PIX_W-1:0] in_red,
   input  wire logic [rthsv_pkg::PIX_W-1:0] in_green,
   input  wire logic [rthsv_pkg::PIX_W-1:0] in_blue,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output rthsv_pkg::div_type            out_data
);

   typedef struct packed {
      logic [rthsv_pkg::PIX_W-1:0] mx;
      logic [rthsv_pkg::PIX_W-1:0] delta;
      rthsv_pkg::sector_type       sector;
      logic [rthsv_pkg::PIX_W-1:0] opa;
      logic [rthsv_pkg::PIX_W-1:0] opc;
   } ext_type;

   logic                va_ff;
   ext_type             a_ff, a_in;
   logic                vb_ff;
   rthsv_pkg::div_type  b_ff, b_in;
   logic                a_ready, b_ready;

   logic [rthsv_pkg::PIX_W-1:0] mx_w, mn_w;
   logic [10:0]                 off_w, n_w, d6_w, den_h;
   logic [15:0]                 snum_w;
   logic [rthsv_pkg::PIX_W-1:0] den_s;
   logic [rthsv_pkg::NUM_W-1:0] hnum_w;

   assign b_ready  = !vb_ff || out_ready;
   assign a_ready  = !va_ff || b_ready;
   assign in_ready = a_ready;

   // stage a: extremes, sector and the two hue operands
   always_comb begin
      mx_w = in_red;
      if (in_green > mx_w) mx_w = in_green;
      if (in_blue > mx_w) mx_w = in_blue;
      mn_w = in_red;
      if (in_green < mn_w) mn_w = in_green;
      if (in_blue < mn_w) mn_w = in_blue;

      a_in.mx    = mx_w;
      a_in.delta = mx_w - mn_w;
      if (in_red == mx_w) begin
         if (in_green >= in_blue) begin
            a_in.sector = rthsv_pkg::SECT_RED_POS;
            a_in.opa    = in_green;
            a_in.opc    = in_blue;
         end else begin
            a_in.sector = rthsv_pkg::SECT_RED_NEG;
            a_in.opa    = in_blue;
            a_in.opc    = in_green;
         end
      end else if (in_green == mx_w) begin
         a_in.sector = rthsv_pkg::SECT_GREEN;
         a_in.opa    = in_blue;
         a_in.opc    = in_red;
      end else begin
         a_in.sector = rthsv_pkg::SECT_BLUE;
         a_in.opa    = in_red;
         a_in.opc    = in_green;
      end
   end

   // stage b: dividends and divisors for both dividers
   always_comb begin
      d6_w = {1'b0, a_ff.delta, 2'b00} + {2'b00, a_ff.delta, 1'b0};
      case (a_ff.sector)
         rthsv_pkg::SECT_GREEN: off_w = {2'b00, a_ff.delta, 1'b0};
         rthsv_pkg::SECT_BLUE:  off_w = {1'b0, a_ff.delta, 2'b00};
         default:               off_w = 11'd0;
      endcase
      n_w    = off_w + {3'b000, a_ff.opa} - {3'b000, a_ff.opc};
      hnum_w = {n_w, 8'h00};
      // negative red sector: ceiling quotient, subtracted from a full turn later
      if (a_ff.sector == rthsv_pkg::SECT_RED_NEG) begin
         hnum_w = hnum_w + {8'h00, d6_w - 11'd1};
      end
      den_h  = (a_ff.delta == '0) ? 11'd1 : d6_w;
      snum_w = {a_ff.delta, 8'h00} - {8'h00, a_ff.delta};
      den_s  = (a_ff.mx == '0) ? 8'd1 : a_ff.mx;

      b_in.hue.rem = hnum_w;
      b_in.hue.dsh = {den_h, 7'b0000000};
      b_in.hue.quo = '0;
      b_in.sat.rem = {3'b000, snum_w};
      b_in.sat.dsh = {3'b000, den_s, 7'b0000000};
      b_in.sat.quo = '0;
      b_in.neg     = (a_ff.sector == rthsv_pkg::SECT_RED_NEG);
      b_in.bright  = a_ff.mx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (a_ready) va_ff <= in_valid;
         if (b_ready) vb_ff <= va_ff;
      end
      if (a_ready && in_valid) a_ff <= a_in;
      if (b_ready && va_ff) b_ff <= b_in;
   end

   assign out_valid = vb_ff;
   assign out_data  = b_ff;

endmodule

`default_nettype wire

// File: hdl/rthsv_div_stage.sv
`default_nettype none

module rthsv_div_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire rthsv_pkg::div_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output rthsv_pkg::div_type      out_data
);

   logic               v_ff;
   rthsv_pkg::div_type d_ff, d_in;

   // one restoring step: one quotient bit per lane
   function automatic rthsv_pkg::lane_type lane_step(input rthsv_pkg::lane_type ln);
      rthsv_pkg::lane_type res;
      logic                ge;
      ge       = (ln.rem >= {1'b0, ln.dsh});
      res.rem  = ge ? (ln.rem - {1'b0, ln.dsh}) : ln.rem;
      res.dsh  = ln.dsh >> 1;
      res.quo  = {ln.quo[rthsv_pkg::PIX_W-2:0], ge};
      return res;
   endfunction

   always_comb begin
      d_in        = in_data;
      d_in.sat    = lane_step(in_data.sat);
      d_in.hue    = lane_step(in_data.hue);
   end

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
      if (in_ready && in_valid) d_ff <= d_in;
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

`default_nettype wire

// File: hdl/rgb_to_hsv_byte_top.sv
// pipeline: 11 register stages from the accepting edge to rsp_valid (2 front,
//    8 divider stages of one quotient bit each, 1 output; the first loads at acceptance)
// throughput: one pixel per clock; each stage stalls only when full and blocked
// reset: synchronous, clears every stage valid bit; the data registers are not reset
`default_nettype none

module rgb_to_hsv_byte_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_hue,
   output logic [7:0]      rsp_saturation,
   output logic [7:0]      rsp_brightness
);

   localparam int NST = rthsv_pkg::DIV_STAGES;

   logic               stg_valid [0:NST];
   logic               stg_ready [0:NST];
   rthsv_pkg::div_type stg_data  [0:NST];

   logic       out_v_ff;
   logic [7:0] hue_ff, hue_in;
   logic [7:0] sat_ff;
   logic [7:0] bright_ff;
   logic       out_ready;

   rthsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_red    (req_red),
      .in_green  (req_green),
      .in_blue   (req_blue),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_data  (stg_data[0])
   );

   for (genvar i = 0; i < NST; i++) begin : g_div
      rthsv_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[i]),
         .in_ready  (stg_ready[i]),
         .in_data   (stg_data[i]),
         .out_valid (stg_valid[i+1]),
         .out_ready (stg_ready[i+1]),
         .out_data  (stg_data[i+1])
      );
   end

   assign out_ready      = !out_v_ff || rsp_ready;
   assign stg_ready[NST] = out_ready;

   // negative red sector wraps: 256 minus the ceiling quotient
   assign hue_in = stg_data[NST].neg ? (8'd0 - stg_data[NST].hue.quo)
                                     : stg_data[NST].hue.quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_ready) begin
         out_v_ff <= stg_valid[NST];
      end
      if (out_ready && stg_valid[NST]) begin
         hue_ff    <= hue_in;
         sat_ff    <= stg_data[NST].sat.quo;
         bright_ff <= stg_data[NST].bright;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bright_ff;

endmodule

`default_nettype wire

// File: hdl/rthsv_checker.sv
`default_nettype none

module rthsv_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_hue,
   input wire logic [7:0] rsp_saturation,
   input wire logic [7:0] rsp_brightness
);

   // a held beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue)
         && $stable(rsp_saturation) && $stable(rsp_brightness))
      else $error("rsp beat changed while stalled");

   // empty output register means the whole pipe can move
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // black pixel has no hue or saturation
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_brightness == 8'd0 |-> rsp_saturation == 8'd0 && rsp_hue == 8'd0)
      else $error("black pixel with color");

   // any chroma gives nonzero saturation, so zero saturation means gray
   a_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturation == 8'd0 |-> rsp_hue == 8'd0)
      else $error("gray pixel with hue");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind rgb_to_hsv_byte_top rthsv_checker u_rthsv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hue        (rsp_hue),
   .rsp_saturation (rsp_saturation),
   .rsp_brightness (rsp_brightness)
);

`default_nettype wire
